@@ hw/rtl/ecmp_pkg.sv @@
`default_nettype none

package ecmp_pkg;

    // Sample width; the payload structs on the ports are sized by it.
    localparam int SAMPLE_BITS  = 16;
    localparam int CHANNELS_DEF = 2;

    // Serial multiplier: multiplicand width and number of multiplier bits.
    localparam int OPER_W    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int MULT_BITS = 17;
    localparam int QUOT_BITS = 16;

    localparam int THR_W      = 15;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0]  THR_RESET     = 15'd16384;
    localparam logic [COEF_W-1:0] SLOPE_RESET   = 16'd49152;
    localparam logic [COEF_W-1:0] ATTACK_RESET  = 16'd65000;
    localparam logic [COEF_W-1:0] RELEASE_RESET = 16'd65500;

    localparam logic [COEF_W-1:0]    GAIN_FLOOR = 16'd6554;
    localparam logic [COEF_W-1:0]    GAIN_MAX   = 16'hFFFF;
    localparam logic [MULT_BITS-1:0] UNITY      = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_SLOPE     = 2'd1,
        CFG_ATTACK    = 2'd2,
        CFG_RELEASE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ENV,
        S_DIV,
        S_PROD,
        S_SCALE,
        S_OUT
    } t_ecmp_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [1:0]                    channel_id;
    } t_ecmp_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          reducing;
    } t_ecmp_out;

    typedef struct packed {
        logic                 start;
        logic [MULT_BITS-1:0] a_mult;
        logic [OPER_W-1:0]    a_cand;
        logic [MULT_BITS-1:0] b_mult;
        logic [OPER_W-1:0]    b_cand;
    } t_mac_req;

    typedef struct packed {
        logic              done;
        logic [OPER_W-1:0] result;
    } t_mac_rsp;

    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] dividend;
        logic [SAMPLE_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ hw/rtl/ecmp_mac.sv @@
`default_nettype none

module ecmp_mac
    import ecmp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mac_req i_req,
    output t_mac_rsp      o_rsp
);

    localparam int CNT_W = $clog2(MULT_BITS);
    localparam int ACC_W = OPER_W + 2;

    logic [MULT_BITS-1:0] r_am;
    logic [MULT_BITS-1:0] r_bm;
    logic [OPER_W-1:0]    r_ac;
    logic [OPER_W-1:0]    r_bc;
    logic [ACC_W-1:0]     r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [ACC_W-1:0] n_addend;
    logic [ACC_W-1:0] n_sum;

    // One multiplier bit of each lane per cycle; dropping the low bit each
    // step keeps the running floor of sum / 2^k.
    assign n_addend = (r_am[0] ? {2'b00, r_ac} : '0) + (r_bm[0] ? {2'b00, r_bc} : '0);
    assign n_sum    = r_acc + n_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_am   <= i_req.a_mult;
                r_bm   <= i_req.b_mult;
                r_ac   <= i_req.a_cand;
                r_bc   <= i_req.b_cand;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(MULT_BITS - 1)) begin
                    // top multiplier bit carries weight 2^16: add, no shift
                    r_acc  <= n_sum;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= n_sum >> 1;
                    r_am  <= r_am >> 1;
                    r_bm  <= r_bm >> 1;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc[OPER_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/ecmp_div.sv @@
`default_nettype none

module ecmp_div
    import ecmp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(QUOT_BITS);

    logic [SAMPLE_BITS-1:0] r_rem;
    logic [SAMPLE_BITS-1:0] r_dvs;
    logic [QUOT_BITS-1:0]   r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [SAMPLE_BITS:0] n_shift;
    logic [SAMPLE_BITS:0] n_diff;
    logic                 n_ge;

    // Restoring division of (dividend << 16) by divisor; dividend < divisor,
    // so the remainder always fits the sample width.
    assign n_shift = {r_rem, 1'b0};
    assign n_diff  = n_shift - {1'b0, r_dvs};
    assign n_ge    = (n_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[SAMPLE_BITS-1:0] : n_shift[SAMPLE_BITS-1:0];
                r_quo <= {r_quo[QUOT_BITS-2:0], n_ge};
                if (r_cnt == CNT_W'(QUOT_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

@@ hw/rtl/envelope_compressor_top.sv @@
// A pass-through channel goes straight to the output register. A sample whose
// envelope stays at or below the threshold takes one serial multiply; when
// gain is applied it takes three 17-step serial multiplies and one 16-step
// serial divide, one bit per cycle. One sample is in flight at a time: the next
// is accepted only after the last has been written to the output register.
// Synchronous reset clears envelopes, configuration registers and all handshakes.
`default_nettype none

module envelope_compressor_top
    import ecmp_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_ecmp_in              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_ecmp_out                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [THR_W-1:0]       r_thr;
    logic [COEF_W-1:0]      r_slope;
    logic [COEF_W-1:0]      r_att;
    logic [COEF_W-1:0]      r_rel;
    logic [SAMPLE_BITS-1:0] r_env [CHANNELS];

    t_ecmp_state            r_state;
    logic [SAMPLE_BITS-1:0] r_raw;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic                   r_neg;
    logic [IDX_W-1:0]       r_idx;
    logic [SAMPLE_BITS-1:0] r_res;
    logic                   r_red;
    t_ecmp_out              r_out;
    logic                   r_out_valid;

    t_ecmp_state            n_state;
    logic [SAMPLE_BITS-1:0] n_raw;
    logic [SAMPLE_BITS-1:0] n_mag;
    logic                   n_neg;
    logic [IDX_W-1:0]       n_idx;
    logic [SAMPLE_BITS-1:0] n_res;
    logic                   n_red;
    t_ecmp_out              n_out;
    logic                   n_out_valid;
    logic                   n_env_we;

    t_mac_req mac_req;
    t_mac_rsp mac_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [SAMPLE_BITS-1:0] thr_s;
    logic [SAMPLE_BITS-1:0] env_cur;
    logic [SAMPLE_BITS-1:0] env_new;
    logic [COEF_W-1:0]      coef;
    logic [IDX_W+1:0]       ch_ext;
    logic                   in_sign;
    logic [COEF_W-1:0]      prod;
    logic [MULT_BITS-1:0]   gain_full;
    logic [COEF_W-1:0]      gain_sat;
    logic [COEF_W-1:0]      gain;
    logic [SAMPLE_BITS-1:0] scaled;

    ecmp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_rsp   (mac_rsp)
    );

    ecmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Bring the Q0.15 threshold to the sample scale.
    generate
        if (SAMPLE_BITS >= 16) begin : g_thr_up
            assign thr_s = SAMPLE_BITS'(r_thr) << (SAMPLE_BITS - 16);
        end else begin : g_thr_dn
            assign thr_s = SAMPLE_BITS'(r_thr >> (16 - SAMPLE_BITS));
        end
    endgenerate

    assign ch_ext  = (IDX_W + 2)'(i_in_data.channel_id);
    assign in_sign = i_in_data.sample_in[SAMPLE_BITS-1];
    assign env_cur = r_env[r_idx];
    assign env_new = mac_rsp.result[SAMPLE_BITS-1:0];
    assign coef    = (r_mag > env_cur) ? r_att : r_rel;

    // Unity gain saturates to all ones; hold the 0.1 floor.
    assign prod      = mac_rsp.result[COEF_W-1:0];
    assign gain_full = UNITY - {1'b0, prod};
    assign gain_sat  = (prod == '0) ? GAIN_MAX : gain_full[COEF_W-1:0];
    assign gain      = (gain_sat < GAIN_FLOOR) ? GAIN_FLOOR : gain_sat;
    assign scaled    = mac_rsp.result[SAMPLE_BITS-1:0];

    always_comb begin
        n_state     = r_state;
        n_raw       = r_raw;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_res       = r_res;
        n_red       = r_red;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_env_we    = 1'b0;
        mac_req     = '0;
        div_req     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_raw = i_in_data.sample_in;
                    n_neg = in_sign;
                    n_mag = in_sign ? (~i_in_data.sample_in + 1'b1) : i_in_data.sample_in;
                    n_idx = ch_ext[IDX_W-1:0];
                    if (int'(i_in_data.channel_id) >= CHANNELS) begin
                        n_res   = i_in_data.sample_in;
                        n_red   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                // env = (c*env + (65536-c)*mag) >> 16
                mac_req.start  = 1'b1;
                mac_req.a_mult = {1'b0, coef};
                mac_req.a_cand = OPER_W'(env_cur);
                mac_req.b_mult = UNITY - {1'b0, coef};
                mac_req.b_cand = OPER_W'(r_mag);
                n_state        = S_ENV;
            end
            S_ENV: begin
                if (mac_rsp.done) begin
                    n_env_we = 1'b1;
                    if (env_new > thr_s) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = thr_s;
                        div_req.divisor  = env_new;
                        n_state          = S_DIV;
                    end else begin
                        n_res   = r_raw;
                        n_red   = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    mac_req.start  = 1'b1;
                    mac_req.a_mult = UNITY - {1'b0, div_rsp.quotient};
                    mac_req.a_cand = OPER_W'(r_slope);
                    n_state        = S_PROD;
                end
            end
            S_PROD: begin
                if (mac_rsp.done) begin
                    mac_req.start  = 1'b1;
                    mac_req.a_mult = {1'b0, gain};
                    mac_req.a_cand = OPER_W'(r_mag);
                    n_state        = S_SCALE;
                end
            end
            S_SCALE: begin
                if (mac_rsp.done) begin
                    n_res   = r_neg ? (~scaled + 1'b1) : scaled;
                    n_red   = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out.sample_out = r_res;
                    n_out.reducing   = r_red;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_raw <= n_raw;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_idx <= n_idx;
        r_res <= n_res;
        r_red <= n_red;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_env[i] <= '0;
            end
        end else if (n_env_we) begin
            r_env[r_idx] <= env_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_slope <= SLOPE_RESET;
            r_att   <= ATTACK_RESET;
            r_rel   <= RELEASE_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                CFG_SLOPE:     r_slope <= i_cfg_data;
                CFG_ATTACK:    r_att   <= i_cfg_data;
                CFG_RELEASE:   r_rel   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/ecmp_chk.sv @@
`default_nettype none

module ecmp_chk
    import ecmp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire t_ecmp_in              i_in_data,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_ecmp_out             o_out_data,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    // Reset empties the block.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear handshakes");

    // One sample at a time: an accepted transaction makes the input busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // A result appears only out of a busy period.
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no sample in flight");

    // Register writes are never refused.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write not accepted");

endmodule

bind envelope_compressor_top ecmp_chk u_ecmp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire
